// ----- sv/aes_pkg.sv -----
// Package with AES-128 constants, the S-box table and round helper functions.
package aes_pkg;

  localparam int unsigned AES_ROUNDS    = 10;
  localparam int unsigned AES_KEY_WORDS = 4;

  localparam logic CFG_KEY_UPPER = 1'b0;
  localparam logic CFG_KEY_LOWER = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constants for rounds 1 to 10.
  localparam logic [7:0] RCON [AES_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits [127-8i -: 8]; column c holds bytes 4c..4c+3.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  // One step of the key schedule: next round key from the previous one.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t = {SBOX[k[23:16]], SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]} ^ {rc, 24'h000000};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ----- sv/aes128_block_encrypt.sv -----
// Top level: AES-128 encryption pipeline with one round per register stage after the key-addition stage.
// The pipeline has 11 register stages: the key-addition stage 0 and round stages 1 to 10.
// Throughput: one word per cycle while the output side does not stall; each round stage carries its own round key.
// The key expands alongside the data inside the pipeline, one schedule step per round stage.
// Reset (rst, synchronous) clears the key registers to zero and all stage valid bits.
// A stall on the output side holds every stage; no word is lost or repeated.
module aes128_block_encrypt import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // cipher_high [63:0], cipher_low [127:64]
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int unsigned NSTG = AES_ROUNDS + 1;

  logic [63:0]  key_upper;
  logic [63:0]  key_lower;
  logic         vld   [NSTG];
  logic [127:0] state [NSTG];
  logic [127:0] rkey  [NSTG];
  logic         adv;

  // The whole pipeline moves when the last stage is empty or drains.
  assign adv      = !vld[NSTG-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NSTG-1];
  assign m_tdata  = {state[NSTG-1][63:0], state[NSTG-1][127:64]};

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_UPPER: key_upper <= cfg_data;
        CFG_KEY_LOWER: key_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 0: initial key addition; the key travels with the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_tvalid;
    end
    if (adv) begin
      state[0] <= {s_tdata[63:0], s_tdata[127:64]} ^ {key_upper, key_lower};
      rkey[0]  <= {key_upper, key_lower};
    end
  end

  // Round stages 1 to 10; the last one skips the column mix.
  for (genvar g = 1; g < NSTG; g++) begin : g_round
    logic [127:0] k_next;
    logic [127:0] sb;
    logic [127:0] mixed;
    assign k_next = next_key(rkey[g-1], RCON[g-1]);
    assign sb     = sub_shift(state[g-1]);
    assign mixed  = (g == NSTG - 1) ? sb : mix_cols(sb);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (adv) begin
        vld[g] <= vld[g-1];
      end
      if (adv) begin
        state[g] <= mixed ^ k_next;
        rkey[g]  <= k_next;
      end
    end
  end

endmodule
